[design/fgpc_pkg.sv]
// ----------------------------------------------------------------------------
// fgpc_pkg
// Shared constants and types for the fuel gauge PWM calibrator: field widths,
// level scaling, calibration segment breakpoints and register indexes.
// ----------------------------------------------------------------------------
package fgpc_pkg;

    // Field widths
    localparam int DATA_W     = 16;
    localparam int LEVEL_W    = 12;
    localparam int CFG_ADDR_W = 3;

    // Level scaling: level = (7500 - count) * 2 / 5
    localparam int LEVEL_BASE  = 7500;
    localparam int LEVEL_NUM_W = 14;   // holds 2 * 7500
    localparam int LEVEL_DIV   = 5;
    localparam int LEVEL_DIV_W = 3;
    localparam int LEVEL_MAX   = 3000;

    // Calibration segments
    localparam int BRK_1     = 125;
    localparam int BRK_2     = 250;
    localparam int BRK_3     = 500;
    localparam int BRK_4     = 750;
    localparam int SEG_NARROW = 125;
    localparam int SEG_WIDE   = 250;
    localparam int SEG_DIV_W  = 8;
    localparam int NUM_CAL    = 6;

    // Datapath widths
    localparam int SLOPE_W  = 28;   // |b - a| * offset
    localparam int FACT_W   = 22;   // signed factor, two's complement
    localparam int FMAG_W   = 20;   // positive factor magnitude
    localparam int SCALED_W = 32;   // level * factor
    localparam int FRAC_BITS = 13;
    localparam int PS_W     = SCALED_W - FRAC_BITS;
    localparam int VOLT_W   = 28;   // v * 2320
    localparam int FINAL_W  = VOLT_W + PS_W;
    localparam int VOLT_SHIFT = 26;

    // Register reset values
    localparam logic [DATA_W-1:0] ADC_OFFSET_RESET = 16'd0;
    localparam logic [DATA_W-1:0] CAL_RESET [NUM_CAL] =
        '{16'd32768, 16'd18104, 16'd15073, 16'd10519, 16'd8847, 16'd8192};

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ADC_OFFSET = 3'd0,
        REG_CAL_0      = 3'd1,
        REG_CAL_125    = 3'd2,
        REG_CAL_250    = 3'd3,
        REG_CAL_500    = 3'd4,
        REG_CAL_750    = 3'd5,
        REG_CAL_1000   = 3'd6
    } cfg_idx_t;

    // Request kinds
    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

endpackage

[design/fgpc_serial_div.sv]
// ----------------------------------------------------------------------------
// fgpc_serial_div
// Bit-serial restoring divider: one quotient bit per cycle, MSB first, with a
// narrow remainder register. Truncating unsigned quotient.
// ----------------------------------------------------------------------------
module fgpc_serial_div
#(
    parameter int N_W = 28,
    parameter int D_W = 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic [N_W-1:0] quotient,
    output logic           done
);

    localparam int CNT_W = $clog2(N_W);

    logic [N_W-1:0]   shift_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   rem_next;
    logic [D_W-1:0]   div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [D_W:0]     trial;
    logic             fits;

    // Trial subtract of the divisor from remainder plus next dividend bit
    always_comb
    begin
        trial    = {rem_reg, shift_reg[N_W-1]};
        fits     = (trial >= {1'b0, div_reg});
        rem_next = fits ? D_W'(trial - {1'b0, div_reg}) : D_W'(trial);
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(N_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            busy_reg <= (cnt_reg != '0);
            done_reg <= (cnt_reg == '0);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Dividend shifts out, quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            div_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[N_W-2:0], fits};
            rem_reg   <= rem_next;
        end
    end

    assign quotient = shift_reg;
    assign done     = done_reg;

endmodule

[design/fgpc_serial_mul.sv]
// ----------------------------------------------------------------------------
// fgpc_serial_mul
// Bit-serial shift-add multiplier: one multiplier bit per cycle, LSB first.
// Only the upper part of the product passes through the adder.
// ----------------------------------------------------------------------------
module fgpc_serial_mul
#(
    parameter int A_W = 16,
    parameter int B_W = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     mcand,
    input  logic [B_W-1:0]     mplier,
    output logic [A_W+B_W-1:0] product,
    output logic               done
);

    localparam int CNT_W = $clog2(B_W);

    logic [A_W+B_W-1:0] prod_reg;
    logic [A_W-1:0]     mcand_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [A_W:0]       part_sum;

    // Add the multiplicand into the upper half when the current bit is set
    always_comb
    begin
        part_sum = {1'b0, prod_reg[A_W+B_W-1:B_W]}
                 + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(B_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            busy_reg <= (cnt_reg != '0);
            done_reg <= (cnt_reg == '0);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Product register shifts right one bit a step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg  <= {{A_W{1'b0}}, mplier};
            mcand_reg <= mcand;
        end
        else if (busy_reg)
        begin
            prod_reg <= {part_sum, prod_reg[B_W-1:1]};
        end
    end

    assign product = prod_reg;
    assign done    = done_reg;

endmodule

[design/fuel_gauge_pwm_calibrator_core.sv]
// ----------------------------------------------------------------------------
// fuel_gauge_pwm_calibrator_core
// Counts sensor edges over a gate interval and, on each gate tick, turns the
// count into a calibrated, battery-compensated PWM compare value.
// ----------------------------------------------------------------------------
// Edge beats: one per cycle while idle, no result.
// Tick beats: one result each from the serial units; the scale and voltage
// multiplies are skipped when the scaled level is zero or negative.
// A new beat is taken once the result sits in the output register.
// Reset (async, active low): edge counter cleared, registers to defaults,
// no clearing pass.
module fuel_gauge_pwm_calibrator_core
    import fgpc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [DATA_W-1:0]     battery_sample,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DATA_W-1:0]     pwm_compare,
    output logic [LEVEL_W-1:0]    raw_level,
    output logic [DATA_W-1:0]     edge_total,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DATA_W-1:0]     cfg_wdata
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_LEVEL = 9'b000000010,
        ST_SEG   = 9'b000000100,
        ST_PROD  = 9'b000001000,
        ST_QUOT  = 9'b000010000,
        ST_FACT  = 9'b000100000,
        ST_SCALE = 9'b001000000,
        ST_VOLT  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [DATA_W-1:0]      adc_offset_reg;
    logic [DATA_W-1:0]      cal_reg [NUM_CAL];
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [31:0]            cnt_ext;

    logic [DATA_W-1:0]      edge_tot_reg;
    logic [DATA_W-1:0]      volt_reg;
    logic [LEVEL_W-1:0]     level_reg;
    logic [DATA_W-1:0]      seg_a_reg;
    logic                   neg_reg;
    logic [SEG_DIV_W-1:0]   width_reg;
    logic [FACT_W-1:0]      fact_reg;
    logic [VOLT_W-1:0]      vmul_reg;
    logic [DATA_W-1:0]      pwm_reg;

    logic                   out_valid_reg;
    logic [DATA_W-1:0]      pwm_out_reg;
    logic [LEVEL_W-1:0]     level_out_reg;
    logic [DATA_W-1:0]      edge_out_reg;

    logic                   in_take;
    logic                   tick_take;
    logic                   edge_take;
    logic                   out_load;
    logic                   fact_pos;

    logic [12:0]            lvl_diff;
    logic [LEVEL_NUM_W-1:0] lvl_num;

    logic [DATA_W-1:0]      seg_a;
    logic [DATA_W-1:0]      seg_b;
    logic [LEVEL_W-1:0]     seg_start;
    logic [SEG_DIV_W-1:0]   seg_width;
    logic [DATA_W:0]        diff_s;
    logic [DATA_W-1:0]      diff_mag;
    logic [LEVEL_W-1:0]     seg_off;
    logic [FMAG_W-1:0]      quot_lo;
    logic [FACT_W-1:0]      fact_next;

    logic [LEVEL_NUM_W-1:0] lvl_quot;
    logic                   lvl_done;
    logic [SLOPE_W-1:0]     slope_prod;
    logic                   slope_done;
    logic [SLOPE_W-1:0]     slope_quot;
    logic                   slope_qdone;
    logic [SCALED_W-1:0]    scaled_prod;
    logic                   scaled_done;
    logic [FINAL_W-1:0]     final_prod;
    logic                   final_done;

    // Handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign tick_take = in_take && (req_type == REQ_TICK);
    assign edge_take = in_take && (req_type == REQ_EDGE);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adc_offset_reg <= ADC_OFFSET_RESET;
            for (int i = 0; i < NUM_CAL; i++)
            begin
                cal_reg[i] <= CAL_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_ADC_OFFSET: adc_offset_reg <= cfg_wdata;
                REG_CAL_0:      cal_reg[0]     <= cfg_wdata;
                REG_CAL_125:    cal_reg[1]     <= cfg_wdata;
                REG_CAL_250:    cal_reg[2]     <= cfg_wdata;
                REG_CAL_500:    cal_reg[3]     <= cfg_wdata;
                REG_CAL_750:    cal_reg[4]     <= cfg_wdata;
                REG_CAL_1000:   cal_reg[5]     <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Saturating edge counter, cleared by a tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (tick_take)
        begin
            count_reg <= '0;
        end
        else if (edge_take && (count_reg != {COUNT_WIDTH{1'b1}}))
        begin
            count_reg <= count_reg + COUNT_WIDTH'(1);
        end
    end

    // Level numerator: 2 * (7500 - count), zero past the base
    always_comb
    begin
        cnt_ext  = 32'(count_reg);
        lvl_diff = 13'(13'(LEVEL_BASE) - cnt_ext[12:0]);
        lvl_num  = (cnt_ext < 32'(LEVEL_BASE)) ? {lvl_diff, 1'b0} : '0;
    end

    // Segment select for the calibration interpolation
    always_comb
    begin
        if (level_reg <= LEVEL_W'(BRK_1))
        begin
            seg_a = cal_reg[0]; seg_b = cal_reg[1];
            seg_start = '0;                seg_width = SEG_DIV_W'(SEG_NARROW);
        end
        else if (level_reg <= LEVEL_W'(BRK_2))
        begin
            seg_a = cal_reg[1]; seg_b = cal_reg[2];
            seg_start = LEVEL_W'(BRK_1);   seg_width = SEG_DIV_W'(SEG_NARROW);
        end
        else if (level_reg <= LEVEL_W'(BRK_3))
        begin
            seg_a = cal_reg[2]; seg_b = cal_reg[3];
            seg_start = LEVEL_W'(BRK_2);   seg_width = SEG_DIV_W'(SEG_WIDE);
        end
        else if (level_reg <= LEVEL_W'(BRK_4))
        begin
            seg_a = cal_reg[3]; seg_b = cal_reg[4];
            seg_start = LEVEL_W'(BRK_3);   seg_width = SEG_DIV_W'(SEG_WIDE);
        end
        else
        begin
            seg_a = cal_reg[4]; seg_b = cal_reg[5];
            seg_start = LEVEL_W'(BRK_4);   seg_width = SEG_DIV_W'(SEG_WIDE);
        end
        diff_s   = {1'b0, seg_b} - {1'b0, seg_a};
        diff_mag = diff_s[DATA_W] ? DATA_W'((DATA_W+1)'(0) - diff_s) : diff_s[DATA_W-1:0];
        seg_off  = level_reg - seg_start;
    end

    // Factor = a +/- |b - a| * offset / width (truncated towards zero)
    always_comb
    begin
        quot_lo   = slope_quot[FMAG_W-1:0];
        fact_next = neg_reg ? (FACT_W'(seg_a_reg) - FACT_W'(quot_lo))
                            : (FACT_W'(seg_a_reg) + FACT_W'(quot_lo));
        fact_pos  = !fact_reg[FACT_W-1] && (fact_reg != '0) && (level_reg != '0);
    end

    // Serial arithmetic units
    fgpc_serial_div #(.N_W(LEVEL_NUM_W), .D_W(LEVEL_DIV_W)) u_lvl_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (tick_take),
        .dividend (lvl_num),
        .divisor  (LEVEL_DIV_W'(LEVEL_DIV)),
        .quotient (lvl_quot),
        .done     (lvl_done)
    );

    fgpc_serial_mul #(.A_W(DATA_W), .B_W(LEVEL_W)) u_slope_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == ST_SEG),
        .mcand   (diff_mag),
        .mplier  (seg_off),
        .product (slope_prod),
        .done    (slope_done)
    );

    fgpc_serial_div #(.N_W(SLOPE_W), .D_W(SEG_DIV_W)) u_slope_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    ((state_reg == ST_PROD) && slope_done),
        .dividend (slope_prod),
        .divisor  (width_reg),
        .quotient (slope_quot),
        .done     (slope_qdone)
    );

    fgpc_serial_mul #(.A_W(FMAG_W), .B_W(LEVEL_W)) u_scale_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   ((state_reg == ST_FACT) && fact_pos),
        .mcand   (fact_reg[FMAG_W-1:0]),
        .mplier  (level_reg),
        .product (scaled_prod),
        .done    (scaled_done)
    );

    fgpc_serial_mul #(.A_W(VOLT_W), .B_W(PS_W)) u_volt_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   ((state_reg == ST_SCALE) && scaled_done),
        .mcand   (vmul_reg),
        .mplier  (scaled_prod[SCALED_W-1:FRAC_BITS]),
        .product (final_prod),
        .done    (final_done)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (tick_take)   state_next = ST_LEVEL;
            ST_LEVEL: if (lvl_done)    state_next = ST_SEG;
            ST_SEG:                    state_next = ST_PROD;
            ST_PROD:  if (slope_done)  state_next = ST_QUOT;
            ST_QUOT:  if (slope_qdone) state_next = ST_FACT;
            ST_FACT:  state_next = fact_pos ? ST_SCALE : ST_DONE;
            ST_SCALE: if (scaled_done) state_next = ST_VOLT;
            ST_VOLT:  if (final_done)  state_next = ST_DONE;
            ST_DONE:  if (out_load)    state_next = ST_IDLE;
            default:                   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working registers of one tick
    always_ff @(posedge clk)
    begin
        if (tick_take)
        begin
            edge_tot_reg <= (cnt_ext > 32'hFFFF) ? 16'hFFFF : cnt_ext[DATA_W-1:0];
            volt_reg     <= battery_sample - adc_offset_reg;
        end
        if ((state_reg == ST_LEVEL) && lvl_done)
        begin
            level_reg <= lvl_quot[LEVEL_W-1:0];
        end
        if (state_reg == ST_SEG)
        begin
            seg_a_reg <= seg_a;
            neg_reg   <= diff_s[DATA_W];
            width_reg <= seg_width;
        end
        if ((state_reg == ST_QUOT) && slope_qdone)
        begin
            fact_reg <= fact_next;
        end
        if (state_reg == ST_FACT)
        begin
            // 2320 = 2^11 + 2^8 + 2^4
            vmul_reg <= (VOLT_W'(volt_reg) << 11) + (VOLT_W'(volt_reg) << 8)
                      + (VOLT_W'(volt_reg) << 4);
            if (!fact_pos)
            begin
                pwm_reg <= '0;
            end
        end
        if ((state_reg == ST_VOLT) && final_done)
        begin
            pwm_reg <= (final_prod[FINAL_W-1:VOLT_SHIFT+DATA_W] != '0)
                     ? {DATA_W{1'b1}}
                     : final_prod[VOLT_SHIFT+DATA_W-1:VOLT_SHIFT];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pwm_out_reg   <= pwm_reg;
            level_out_reg <= level_reg;
            edge_out_reg  <= edge_tot_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pwm_compare = pwm_out_reg;
    assign raw_level   = level_out_reg;
    assign edge_total  = edge_out_reg;

endmodule

[design/fgpc_checker.sv]
// ----------------------------------------------------------------------------
// fgpc_checker
// Port-level checks for the fuel gauge PWM calibrator, bound to the core.
// ----------------------------------------------------------------------------
module fgpc_checker
    import fgpc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  req_type,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [DATA_W-1:0]     pwm_compare,
    input logic [LEVEL_W-1:0]    raw_level,
    input logic [DATA_W-1:0]     edge_total
);

    // A stalled result beat stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pwm_compare) && $stable(raw_level)
                                   && $stable(edge_total))
        else $error("result payload changed while stalled");

    // Level stays within full scale
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> raw_level <= LEVEL_W'(LEVEL_MAX))
        else $error("raw level above full scale");

    // A tick starts the calculation and holds off further beats
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == REQ_TICK) |=> in_stall)
        else $error("tick accepted without going busy");

    // Zero level gives zero drive
    a_zero_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (raw_level == '0) |-> pwm_compare == '0)
        else $error("non-zero PWM at empty level");

endmodule

bind fuel_gauge_pwm_calibrator_core fgpc_checker u_fgpc_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fuel_gauge_pwm_calibrator_core. A behavioural
// predictor tracks the edge counter and the calibration registers. For every
// accepted tick beat it works out the level, the interpolated factor and the
// battery-compensated PWM value. A checker compares each result beat against
// the oldest pending prediction. The tests cover level rounding, register
// extremes, back-to-back ticks, output back-pressure and a random phase.
// ----------------------------------------------------------------------------
module testbench;
    import fgpc_pkg::*;

    localparam int     COUNT_W           = 16;
    localparam int     NUM_REGS          = 7;
    localparam int     LEVEL_MUL         = 2;      // level = (base - count) * 2 / 5
    localparam longint VOLT_MUL          = 2320;
    localparam longint PWM_MAX           = 65535;
    localparam int     SETTLE_CYCLES     = 120;    // past the longest tick latency
    localparam int     HOLD_CYCLES       = 600;
    localparam int     RANDOM_TICKS      = 24;
    localparam int     TICKS_PER_SETTING = 8;
    localparam int     CLOSE_TICKS       = 6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;   // not decoded

    typedef struct packed {
        logic [DATA_W-1:0]  pwm;
        logic [LEVEL_W-1:0] level;
        logic [DATA_W-1:0]  total;
    } gauge_result_t;

    typedef logic [DATA_W-1:0] reg_set_t [NUM_REGS];

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  req_type;
    logic [DATA_W-1:0]     battery_sample;
    logic                  out_valid;
    logic                  out_stall;
    logic [DATA_W-1:0]     pwm_compare;
    logic [LEVEL_W-1:0]    raw_level;
    logic [DATA_W-1:0]     edge_total;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [DATA_W-1:0]     cfg_wdata;

    // Predictor state
    logic [DATA_W-1:0]  gauge_reg [NUM_REGS];
    logic [COUNT_W-1:0] edge_cnt;
    gauge_result_t      gauge_expected [$];
    gauge_result_t      oldest_result;

    // Bench control
    int   err_count   = 0;
    int   sink_hold   = 0;
    bit   sender_idles = 1'b0;
    bit   sink_idles   = 1'b1;
    logic last_kind    = REQ_EDGE;

    always #5 clk = ~clk;

    fuel_gauge_pwm_calibrator_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .battery_sample (battery_sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pwm_compare    (pwm_compare),
        .raw_level      (raw_level),
        .edge_total     (edge_total),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata)
    );

    // Tick arithmetic: level, interpolated factor, voltage compensation
    function automatic gauge_result_t gauge_tick(input logic [COUNT_W-1:0] count,
                                                 input logic [DATA_W-1:0] sample);
        longint            cnt, lvl, a, b, start, width, factor, scaled, volts, pwm;
        int                seg;
        logic [DATA_W-1:0] diff;
        gauge_result_t     res;
        cnt = count;
        lvl = (cnt < LEVEL_BASE) ? ((LEVEL_BASE - cnt) * LEVEL_MUL) / LEVEL_DIV : 0;
        if (lvl <= BRK_1)
        begin
            seg = 0; start = 0; width = SEG_NARROW;
        end
        else if (lvl <= BRK_2)
        begin
            seg = 1; start = BRK_1; width = SEG_NARROW;
        end
        else if (lvl <= BRK_3)
        begin
            seg = 2; start = BRK_2; width = SEG_WIDE;
        end
        else if (lvl <= BRK_4)
        begin
            seg = 3; start = BRK_3; width = SEG_WIDE;
        end
        else
        begin
            // beyond 1000 the last segment is extrapolated
            seg = 4; start = BRK_4; width = SEG_WIDE;
        end
        a = gauge_reg[REG_CAL_0 + seg];
        b = gauge_reg[REG_CAL_0 + seg + 1];
        factor = a + ((b - a) * (lvl - start)) / width;   // truncates toward zero
        scaled = lvl * factor;
        if (scaled <= 0)
            pwm = 0;
        else
        begin
            diff  = sample - gauge_reg[REG_ADC_OFFSET];   // 16-bit wrap
            volts = diff;
            pwm   = ((scaled >>> FRAC_BITS) * volts * VOLT_MUL) >>> VOLT_SHIFT;
            if (pwm > PWM_MAX)
                pwm = PWM_MAX;
        end
        res.pwm   = pwm[DATA_W-1:0];
        res.level = lvl[LEVEL_W-1:0];
        res.total = count;
        return res;
    endfunction

    // Register value biased towards the extremes
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic reg_set_t random_setting();
        reg_set_t vals;
        foreach (vals[i])
            vals[i] = pick_value();
        return vals;
    endfunction

    // One input beat, with optional idle gap ahead of it; prediction on accept
    task automatic send_beat(input logic kind, input logic [DATA_W-1:0] sample);
        int gap;
        gap = 0;
        if (sender_idles && $urandom_range(99) < 36)
            gap = (kind == REQ_TICK || last_kind == REQ_TICK) ?
                  $urandom_range(1, 120) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        req_type       <= kind;
        battery_sample <= sample;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        last_kind = kind;
        if (kind == REQ_EDGE)
        begin
            if (edge_cnt != {COUNT_W{1'b1}})
                edge_cnt++;
        end
        else
        begin
            gauge_expected.push_back(gauge_tick(edge_cnt, sample));
            edge_cnt = '0;
        end
    endtask

    task automatic edges_then_tick(input int n, input logic [DATA_W-1:0] sample);
        repeat (n)
            send_beat(REQ_EDGE, DATA_W'($urandom));
        send_beat(REQ_TICK, sample);
    endtask

    // Sender pauses until every pending result is out, then lets the block settle
    task automatic await_results();
        in_valid <= 1'b0;
        while (gauge_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes every register, then a spare index that must be dropped
    task automatic load_regs(input reg_set_t vals);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_ADDR_W'(i);
            cfg_wdata <= vals[i];
            @(posedge clk);
            gauge_reg[i] = vals[i];
        end
        cfg_addr  <= REG_SPARE;
        cfg_wdata <= DATA_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Reset registers: rounding of the level near full scale
    task automatic test_level_rounding();
        int counts [10] = '{0, 1, 2, 3, 4, 5, 7, 10, 20, 40};
        sender_idles = 1'b0;
        foreach (counts[i])
        begin
            if (i == 0)
                edges_then_tick(counts[i], '1);
            else if (i == 1)
                edges_then_tick(counts[i], '0);
            else
                edges_then_tick(counts[i], DATA_W'($urandom));
        end
        await_results();
    endtask

    // Zero and full-scale registers, saturation, negative factor, offset wrap
    task automatic test_register_extremes();
        reg_set_t vals;
        logic [DATA_W-1:0] sample;

        foreach (vals[i]) vals[i] = '0;
        load_regs(vals);
        edges_then_tick(0, '1);
        edges_then_tick(30, '1);
        await_results();

        foreach (vals[i]) vals[i] = '1;
        vals[REG_ADC_OFFSET] = '0;
        load_regs(vals);
        edges_then_tick(0, '1);
        edges_then_tick(40, '1);
        await_results();

        // steep rise past 750 drives the result into the clamp
        vals = random_setting();
        vals[REG_ADC_OFFSET] = '0;
        vals[REG_CAL_750]    = '0;
        vals[REG_CAL_1000]   = '1;
        load_regs(vals);
        edges_then_tick(0, '1);
        edges_then_tick(20, 16'hC000);
        await_results();

        // steep fall past 750 takes the factor below zero
        vals[REG_CAL_750]  = '1;
        vals[REG_CAL_1000] = '0;
        load_regs(vals);
        edges_then_tick(0, '1);
        edges_then_tick(25, '1);
        await_results();

        // offset above the sample wraps; offset equal to it gives no voltage
        vals = random_setting();
        vals[REG_ADC_OFFSET] = '1;
        load_regs(vals);
        edges_then_tick(10, '0);
        await_results();
        sample = DATA_W'($urandom);
        vals[REG_ADC_OFFSET] = sample;
        load_regs(vals);
        edges_then_tick(10, sample);
        await_results();
    endtask

    // Ticks with no edges between them, offered back to back
    task automatic test_close_ticks();
        sender_idles = 1'b0;
        repeat (CLOSE_TICKS)
            edges_then_tick(0, DATA_W'($urandom));
        await_results();
    endtask

    // Receiver holds off while the sender keeps offering beats
    task automatic test_back_pressure();
        sender_idles = 1'b1;
        sink_hold    = HOLD_CYCLES;
        repeat (5)
            edges_then_tick($urandom_range(0, 8), DATA_W'($urandom));
        await_results();
    endtask

    // Random gate intervals, fresh settings per phase
    task automatic test_random_ticks();
        int                n;
        logic [DATA_W-1:0] sample;
        for (int t = 0; t < RANDOM_TICKS; t++)
        begin
            if (t % TICKS_PER_SETTING == 0)
            begin
                await_results();
                load_regs(random_setting());
            end
            // one phase with no idling on either side
            sender_idles = !(t >= 16 && t < 24);
            sink_idles   = sender_idles;
            case ($urandom_range(2))
                0:       n = 0;
                1:       n = $urandom_range(1, 4);
                default: n = $urandom_range(5, 24);
            endcase
            case ($urandom_range(3))
                0:       sample = gauge_reg[REG_ADC_OFFSET] + DATA_W'($urandom_range(64));
                1:       sample = $urandom_range(1) ? '1 : '0;
                default: sample = DATA_W'($urandom);
            endcase
            edges_then_tick(n, sample);
        end
        sink_idles = 1'b1;
    endtask

    // Receiver: random stall, or a counted hold-off when one is requested
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                out_stall <= 1'b1;
                sink_hold--;
            end
            else if (sink_idles)
                out_stall <= ($urandom_range(99) < 36);
            else
                out_stall <= 1'b0;
        end
    end

    // Result checker: each result beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (gauge_expected.size() == 0)
            begin
                $error("result beat with no tick pending: pwm_compare %0d", pwm_compare);
                err_count++;
            end
            else
            begin
                oldest_result = gauge_expected.pop_front();
                if (pwm_compare !== oldest_result.pwm)
                begin
                    $error("pwm_compare: expected %0d, got %0d",
                           oldest_result.pwm, pwm_compare);
                    err_count++;
                end
                if (raw_level !== oldest_result.level)
                begin
                    $error("raw_level: expected %0d, got %0d",
                           oldest_result.level, raw_level);
                    err_count++;
                end
                if (edge_total !== oldest_result.total)
                begin
                    $error("edge_total: expected %0d, got %0d",
                           oldest_result.total, edge_total);
                    err_count++;
                end
            end
        end
    end

    // Run limit
    initial
    begin
        #80ms;
        $display("status: fail");
        $finish;
    end

    // Test sequence
    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        req_type       <= REQ_EDGE;
        battery_sample <= '0;
        cfg_we         <= 1'b0;
        cfg_addr       <= REG_ADC_OFFSET;
        cfg_wdata      <= '0;
        gauge_reg[REG_ADC_OFFSET] = ADC_OFFSET_RESET;
        for (int i = 0; i < NUM_CAL; i++)
            gauge_reg[REG_CAL_0 + i] = CAL_RESET[i];
        edge_cnt = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_level_rounding();
        test_register_extremes();
        test_close_ticks();
        test_back_pressure();
        test_random_ticks();
        await_results();

        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
design/fgpc_pkg.sv
design/fgpc_serial_div.sv
design/fgpc_serial_mul.sv
design/fuel_gauge_pwm_calibrator_core.sv
design/fgpc_checker.sv
tb/sv/testbench.sv
